/* design/lsws_pkg.sv */
// Shared types, codes and default sizes for the LIFO stack with swap.
package lsws_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 8;
	localparam int COUNT_W   = 9;
	localparam int EXT_W     = 64;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_SWAP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_EMPTY      = 3'd1,
		STAT_FULL       = 3'd2,
		STAT_BAD_INDEX  = 3'd3,
		STAT_SAME_INDEX = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWAP_WR1,
		S_SWAP_WR2,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t                  op;
		logic [VALUE_W-1:0]   push_value;
		logic [INDEX_W-1:0]   first_depth;
		logic [INDEX_W-1:0]   second_depth;
	} req_t;

	typedef struct packed {
		logic                 is_empty;
		logic [COUNT_W-1:0]   entry_count;
		status_t              status;
		logic [VALUE_W-1:0]   read_value;
	} res_t;

endpackage

/* design/lsws_engine.sv */
// Stack engine: entry memory, count and the request sequencer.
module lsws_engine
	import lsws_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q;
	op_t                   op_q;
	status_t               status_q;
	logic [AW-1:0]         slot_a_q, slot_b_q;
	logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;

	logic                  acc;
	logic                  full, empty, bad, same;
	status_t               status_d;
	logic [MW-1:0]         cnt_w, d1_w, d2_w;
	logic [AW-1:0]         slot_a_d, slot_b_d;

	logic                  we, rd_en;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;

	logic signed [DATA_WIDTH-1:0] rd_sgn;
	logic signed [EXT_W-1:0]      rd_ext;

	// Decode the request against the current count
	always_comb begin
		acc   = req_valid && req_ready;
		full  = (count_q == CW'(DEPTH));
		empty = (count_q == '0);
		cnt_w = MW'(count_q);
		d1_w  = MW'(req.first_depth);
		d2_w  = MW'(req.second_depth);
		same  = (req.first_depth == req.second_depth);
		bad   = (d1_w >= cnt_w) || (d2_w >= cnt_w);
		unique case (req.op)
			OP_PUSH: status_d = full ? STAT_FULL : STAT_OK;
			OP_POP,
			OP_PEEK: status_d = empty ? STAT_EMPTY : STAT_OK;
			OP_SWAP: status_d = same ? STAT_SAME_INDEX : (bad ? STAT_BAD_INDEX : STAT_OK);
			default: status_d = STAT_OK;
		endcase
		if (req.op == OP_SWAP) begin
			slot_a_d = AW'(cnt_w - MW'(1) - d1_w);
			slot_b_d = AW'(cnt_w - MW'(1) - d2_w);
		end else begin
			slot_a_d = AW'(count_q - CW'(1));
			slot_b_d = AW'(count_q - CW'(1));
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.op == OP_SWAP && status_d == STAT_OK) state_d = S_SWAP_WR1;
					else state_d = S_RESP;
				end
			end
			S_SWAP_WR1: state_d = S_SWAP_WR2;
			S_SWAP_WR2: if (res_ready) state_d = S_IDLE;
			S_RESP:     if (res_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory control and result outputs
	always_comb begin
		req_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_RESP) || (state_q == S_SWAP_WR2);
		we        = 1'b0;
		rd_en     = 1'b0;
		waddr     = slot_a_q;
		wdata     = rd_b_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && status_d == STAT_OK) begin
					if (req.op == OP_PUSH) begin
						we    = 1'b1;
						waddr = AW'(count_q);
						wdata = DATA_WIDTH'(req.push_value);
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_SWAP_WR1: begin
				we    = 1'b1;
				waddr = slot_a_q;
				wdata = rd_b_q;
			end
			S_SWAP_WR2: begin
				// repeated while stalled, which is harmless
				we    = 1'b1;
				waddr = slot_b_q;
				wdata = rd_a_q;
			end
			S_RESP:  ;
			default: ;
		endcase

		rd_sgn = rd_a_q;
		rd_ext = EXT_W'(rd_sgn);
		res.status      = status_q;
		res.entry_count = COUNT_W'(count_q);
		res.is_empty    = (count_q == '0);
		if ((op_q == OP_POP || op_q == OP_PEEK) && status_q == STAT_EMPTY)
			res.read_value = '1;
		else if ((op_q == OP_POP || op_q == OP_PEEK) && status_q == STAT_OK)
			res.read_value = rd_ext[VALUE_W-1:0];
		else
			res.read_value = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc && status_d == STAT_OK) begin
				if (req.op == OP_PUSH) count_q <= count_q + CW'(1);
				else if (req.op == OP_POP) count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= req.op;
			status_q <= status_d;
			slot_a_q <= slot_a_d;
			slot_b_q <= slot_b_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) begin
			rd_a_q <= mem[slot_a_d];
			rd_b_q <= mem[slot_b_d];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_PUSH && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("accepted push did not advance count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && rd_en))
		else $error("memory read and write in the same cycle");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STAT_EMPTY) |-> (count_q == '0))
		else $error("empty status with entries held");

	a_resp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (state_q == S_IDLE))
		else $error("sequencer not idle after result");

endmodule

/* design/lifo_stack_with_swap_unit.sv */
// Top level of the LIFO stack with swap: stream ports and result register.
//
//  channel   dir  fields (lowest bit first)
//  s_*       in   tuser: operation[1:0]
//                 tdata: push_value[31:0], first_depth[39:32], second_depth[47:40]
//  m_*       out  tdata: read_value[31:0], status[34:32], entry_count[43:35],
//                        is_empty[44], zero fill[47:45]
//
// Push, pop and peek are accepted, then give the result. A swap that
// exchanges entries is accepted with both entries read, then does one write
// per memory slot, since the entry memory has a single write port; a swap that
// reports same or bad index goes from accept to the result like the other requests.
// One request is in the engine at a time; the result register lets a new
// request be accepted while the previous result waits on m_tready.
// Reset clears the count and the handshake state; the entry memory is not
// cleared, as only entries below the count are ever read.
module lifo_stack_with_swap_unit
	import lsws_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // push_value, first_depth, second_depth
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // read_value, status, entry_count, is_empty
);

	req_t req;
	res_t res;
	res_t res_q;
	logic res_valid, res_ready;
	logic m_tvalid_q;

	// Unpack the request fields
	always_comb begin
		req.op           = op_t'(s_tuser);
		req.push_value   = s_tdata[VALUE_W-1:0];
		req.first_depth  = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
		req.second_depth = s_tdata[VALUE_W+2*INDEX_W-1:VALUE_W+INDEX_W];
	end

	lsws_engine #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Take a new result when the register is empty or draining this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	// Hold the result payload until it is taken
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.is_empty, res_q.entry_count, res_q.status,
		res_q.read_value};

endmodule
